// ===== rtl/core/lcfr_pkg.sv =====
// Shared types and constants for the length/checksum frame receiver.
// No dependencies; every rtl/core module imports this package.
package lcfr_pkg;

    localparam int BUF_BYTES   = 64;                     // frame store per bank, 8..256
    localparam int ADDR_W      = $clog2(BUF_BYTES);
    localparam int MEM_AW      = ADDR_W + 1;             // bank bit + offset
    localparam int MEM_DEPTH   = 2 * BUF_BYTES;
    localparam int CNT_W       = 6;
    localparam int MAX_PAYLOAD = 59;
    localparam int MIN_LEN     = 3;
    localparam int HDR_BYTES   = 5;
    localparam int OFF_LEN     = 1;
    localparam int OFF_SRC     = 3;
    localparam int OFF_CMD     = 4;
    localparam int MAX_LEN     = (BUF_BYTES - 3 < MAX_PAYLOAD + 3) ?
                                 (BUF_BYTES - 3) : (MAX_PAYLOAD + 3);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic              bank;
        t_byte             src;
        t_byte             cmd;
        logic [CNT_W-1:0]  cnt;
    } t_desc;

    typedef struct packed {
        logic vld;
        logic bank;
    } t_release;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        t_byte             data;
    } t_mem_wr;

    typedef struct packed {
        t_byte             src;
        t_byte             cmd;
        t_byte             data;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_result;

endpackage

// ===== rtl/core/lcfr_store.sv =====
// Two-bank frame store: one write port (front), one registered read port (back).
// Depends on lcfr_pkg.
module lcfr_store (
    input  logic                   i_clk,
    input  lcfr_pkg::t_mem_wr      i_wr,
    input  logic                   i_rd_en,
    input  logic [lcfr_pkg::MEM_AW-1:0] i_rd_addr,
    output lcfr_pkg::t_byte        o_rd_data
);
    import lcfr_pkg::*;

    t_byte r_mem [MEM_DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/lcfr_front.sv =====
// Front end: takes bytes, tracks length and running sum, writes the frame store
// and posts a descriptor per good frame. Owns the bank busy flags. Uses lcfr_pkg.
module lcfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcfr_pkg::t_byte    i_rx_byte,
    output logic               o_full,
    output lcfr_pkg::t_mem_wr  o_wr,
    output logic               o_desc_push,
    output lcfr_pkg::t_desc    o_desc,
    input  lcfr_pkg::t_release i_release
);
    import lcfr_pkg::*;

    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_len, n_len;
    t_byte             r_sum, n_sum;
    t_byte             r_src, n_src;
    t_byte             r_cmd, n_cmd;
    logic              r_wbank, n_wbank;
    logic [1:0]        r_busy, n_busy;
    logic              accept;

    assign o_full = r_busy[r_wbank];
    assign accept = i_push & ~o_full;

    always_comb begin
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_sum       = r_sum;
        n_src       = r_src;
        n_cmd       = r_cmd;
        n_wbank     = r_wbank;
        n_busy      = r_busy;
        o_desc_push = 1'b0;

        o_wr.we   = accept;
        o_wr.addr = {r_wbank, r_cnt};
        o_wr.data = i_rx_byte;

        o_desc.bank = r_wbank;
        o_desc.src  = r_src;
        o_desc.cmd  = r_cmd;
        o_desc.cnt  = CNT_W'(r_len - ADDR_W'(MIN_LEN));

        if (i_release.vld) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            if (r_cnt == ADDR_W'(OFF_LEN)) begin
                // length byte: reject short or oversized frames right away
                if (i_rx_byte < 8'(MIN_LEN) || i_rx_byte > 8'(MAX_LEN)) begin
                    n_cnt = '0;
                    n_sum = '0;
                end else begin
                    n_len = i_rx_byte[ADDR_W-1:0];
                    n_cnt = r_cnt + 1'b1;
                    n_sum = r_sum + i_rx_byte;
                end
            end else if (r_cnt != '0 && r_cnt == r_len + ADDR_W'(2)) begin
                // checksum byte
                if (i_rx_byte == r_sum) begin
                    o_desc_push     = 1'b1;
                    n_busy[r_wbank] = 1'b1;
                    n_wbank         = ~r_wbank;
                end
                n_cnt = '0;
                n_sum = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
                n_sum = r_sum + i_rx_byte;
                if (r_cnt == ADDR_W'(OFF_SRC)) begin
                    n_src = i_rx_byte;
                end
                if (r_cnt == ADDR_W'(OFF_CMD)) begin
                    n_cmd = i_rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_src <= n_src;
        r_cmd <= n_cmd;
    end

endmodule

// ===== rtl/core/lcfr_desc_q.sv =====
// Two-entry descriptor queue between front and back end.
// Depends on lcfr_pkg.
module lcfr_desc_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcfr_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_empty,
    output lcfr_pkg::t_desc o_desc
);
    import lcfr_pkg::*;

    t_desc      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_occ;
    logic       do_pop;

    assign o_empty = (r_occ == 2'd0);
    assign o_desc  = r_q[r_rp];
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_occ <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_occ <= r_occ + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/lcfr_back.sv =====
// Back end: walks a good frame's payload in the store, one read per cycle when
// output queue room allows; results go to a two-entry output queue. Uses lcfr_pkg.
module lcfr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_desc_empty,
    input  lcfr_pkg::t_desc             i_desc,
    output logic                        o_desc_pop,
    output logic                        o_rd_en,
    output logic [lcfr_pkg::MEM_AW-1:0] o_rd_addr,
    input  lcfr_pkg::t_byte             i_rd_data,
    output lcfr_pkg::t_release          o_release,
    input  logic                        i_pop,
    output logic                        o_empty,
    output lcfr_pkg::t_result           o_result
);
    import lcfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_desc            r_desc, n_desc;
    logic [CNT_W-1:0] r_k, n_k;
    logic             issue_ok, is_last;

    // read pipeline stage
    logic             r_p_vld;
    t_byte            r_p_src, r_p_cmd;
    logic [CNT_W-1:0] r_p_cnt;
    logic             r_p_last, r_p_zero;

    // output queue
    t_result          r_oq [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_occ;
    logic             oq_pop;
    t_result          p_res;

    // conservative credit: queue entries plus the read in flight
    assign issue_ok = (r_occ == 2'd0) || (r_occ == 2'd1 && !r_p_vld);
    assign is_last  = (r_desc.cnt == '0) || (r_k == r_desc.cnt - 1'b1);
    assign o_rd_addr = {r_desc.bank, ADDR_W'(HDR_BYTES) + ADDR_W'(r_k)};

    always_comb begin
        n_state        = r_state;
        n_desc         = r_desc;
        n_k            = r_k;
        o_desc_pop     = 1'b0;
        o_rd_en        = 1'b0;
        o_release.vld  = 1'b0;
        o_release.bank = r_desc.bank;
        case (r_state)
            S_IDLE: begin
                if (!i_desc_empty) begin
                    o_desc_pop = 1'b1;
                    n_desc     = i_desc;
                    n_k        = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (issue_ok) begin
                    o_rd_en = 1'b1;
                    n_k     = r_k + 1'b1;
                    if (is_last) begin
                        // read is taken at this edge, so the bank is free after it
                        o_release.vld = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_k    <= n_k;
        if (o_rd_en) begin
            r_p_src  <= r_desc.src;
            r_p_cmd  <= r_desc.cmd;
            r_p_cnt  <= r_desc.cnt;
            r_p_last <= is_last;
            r_p_zero <= (r_desc.cnt == '0);
        end
    end

    always_comb begin
        p_res.src  = r_p_src;
        p_res.cmd  = r_p_cmd;
        p_res.data = r_p_zero ? '0 : i_rd_data;
        p_res.cnt  = r_p_cnt;
        p_res.last = r_p_last;
    end

    assign o_empty  = (r_occ == 2'd0);
    assign o_result = r_oq[r_rp];
    assign oq_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_oq[r_wp] <= p_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_occ <= 2'd0;
        end else begin
            if (r_p_vld) begin
                r_wp <= ~r_wp;
            end
            if (oq_pop) begin
                r_rp <= ~r_rp;
            end
            r_occ <= r_occ + {1'b0, r_p_vld} - {1'b0, oq_pop};
        end
    end

endmodule

// ===== rtl/core/length_checksum_frame_receiver.sv =====
// Frame receiver: one byte request per cycle while a store bank is free.
// After a good checksum byte, its descriptor passes the descriptor queue, the back end's
// idle state and the store read before its result enters the output queue. The back end
// only issues a store read when the output queue and the read in flight leave room.
// full rises only when both store banks hold frames still being drained.
// Synchronous active-low reset clears counters, queues and bank flags; store is not cleared.
module length_checksum_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_source_id,
    output logic [7:0]                     o_command_code,
    output logic [7:0]                     o_payload_byte,
    output logic [lcfr_pkg::CNT_W-1:0]     o_payload_count,
    output logic                           o_last
);
    import lcfr_pkg::*;

    t_mem_wr           mem_wr;
    t_desc             desc_in, desc_head;
    logic              desc_push, desc_pop, desc_empty;
    t_release          release_s;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    t_byte             rd_data;
    t_result           res;

    lcfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .o_wr        (mem_wr),
        .o_desc_push (desc_push),
        .o_desc      (desc_in),
        .i_release   (release_s)
    );

    lcfr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lcfr_desc_q u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_empty (desc_empty),
        .o_desc  (desc_head)
    );

    lcfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_empty (desc_empty),
        .i_desc       (desc_head),
        .o_desc_pop   (desc_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_release    (release_s),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (res)
    );

    assign o_source_id     = res.src;
    assign o_command_code  = res.cmd;
    assign o_payload_byte  = res.data;
    assign o_payload_count = res.cnt;
    assign o_last          = res.last;

endmodule

// ===== rtl/core/lcfr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
// Depends on lcfr_pkg and length_checksum_frame_receiver.
module lcfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [7:0]                 o_source_id,
    input logic [7:0]                 o_command_code,
    input logic [7:0]                 o_payload_byte,
    input logic [lcfr_pkg::CNT_W-1:0] o_payload_count,
    input logic                       o_last
);
    import lcfr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_payload_byte) && $stable(o_last) &&
                           $stable(o_source_id) && $stable(o_command_code))
        else $error("waiting result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_payload_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count out of range");

    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_payload_count == '0 |-> o_last && o_payload_byte == 8'd0)
        else $error("empty payload result malformed");

endmodule

bind length_checksum_frame_receiver lcfr_checker u_lcfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_source_id     (o_source_id),
    .o_command_code  (o_command_code),
    .o_payload_byte  (o_payload_byte),
    .o_payload_count (o_payload_count),
    .o_last          (o_last)
);
